### src/pcs_pkg.sv
package pcs_pkg;

	localparam int CRD_W = 32;
	localparam int RAD_W = 31;

	// command codes as they appear on the func port
	typedef enum logic [3:0] {
		F_MOVE, F_LINE, F_HLINE, F_VLINE, F_QUAD, F_SQUAD, F_CUBIC, F_SCUBIC,
		F_CLOSE, F_RECT, F_CIRCLE, F_RRECT_UNI, F_RRECT_FOUR, F_ELLIPSE,
		F_SPARE_A, F_SPARE_B
	} func_code_t;

	// segment kinds as they appear on the seg_kind port
	localparam logic [1:0] SEG_LINE  = 2'd0;
	localparam logic [1:0] SEG_QUAD  = 2'd1;
	localparam logic [1:0] SEG_CUBIC = 2'd2;
	localparam logic [1:0] SEG_NONE  = 2'd3;

	// command class as seen by the back end
	typedef enum logic [3:0] {
		OP_MOVE,
		OP_LINE,
		OP_HLINE,
		OP_VLINE,
		OP_QUAD,
		OP_SQUAD,
		OP_CUBIC,
		OP_SCUBIC,
		OP_CLOSE,
		OP_RECT,
		OP_RRECT,
		OP_ELLIPSE
	} op_t;

	// classified command, radii already steered to corner order
	typedef struct packed {
		op_t                     op;
		logic                    rel;
		logic signed [CRD_W-1:0] ax;
		logic signed [CRD_W-1:0] ay;
		logic signed [CRD_W-1:0] bx;
		logic signed [CRD_W-1:0] by;
		logic signed [CRD_W-1:0] cx;
		logic signed [CRD_W-1:0] cy;
		logic [RAD_W-1:0]        ra;
		logic [RAD_W-1:0]        rb;
		logic [RAD_W-1:0]        rc;
		logic [RAD_W-1:0]        rd;
	} cmd_t;

	// queue status towards the front end
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### src/pcs_front.sv
module pcs_front import pcs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [3:0]              func,
	input  logic                    relative,
	input  logic signed [CRD_W-1:0] pa_x,
	input  logic signed [CRD_W-1:0] pa_y,
	input  logic signed [CRD_W-1:0] pb_x,
	input  logic signed [CRD_W-1:0] pb_y,
	input  logic signed [CRD_W-1:0] pc_x,
	input  logic signed [CRD_W-1:0] pc_y,
	input  logic [RAD_W-1:0]        rad_a,
	input  logic [RAD_W-1:0]        rad_b,
	input  logic [RAD_W-1:0]        rad_c,
	input  logic [RAD_W-1:0]        rad_d,
	input  q_stat_t                 q_stat,
	output logic                    push,
	output cmd_t                    push_cmd
);

	cmd_t cmd_d;
	logic keep_d;
	cmd_t cmd_s1;
	logic valid_s1;
	logic load;

	// classify the command and steer the radii
	always_comb begin
		cmd_d     = '0;
		cmd_d.rel = relative;
		cmd_d.ax  = pa_x;
		cmd_d.ay  = pa_y;
		cmd_d.bx  = pb_x;
		cmd_d.by  = pb_y;
		cmd_d.cx  = pc_x;
		cmd_d.cy  = pc_y;
		cmd_d.ra  = rad_a;
		cmd_d.rb  = rad_a;
		cmd_d.rc  = rad_a;
		cmd_d.rd  = rad_a;
		cmd_d.op  = OP_MOVE;
		keep_d    = 1'b1;
		case (func)
			F_MOVE:   cmd_d.op = OP_MOVE;
			F_LINE:   cmd_d.op = OP_LINE;
			F_HLINE:  cmd_d.op = OP_HLINE;
			F_VLINE:  cmd_d.op = OP_VLINE;
			F_QUAD:   cmd_d.op = OP_QUAD;
			F_SQUAD:  cmd_d.op = OP_SQUAD;
			F_CUBIC:  cmd_d.op = OP_CUBIC;
			F_SCUBIC: cmd_d.op = OP_SCUBIC;
			F_CLOSE:  cmd_d.op = OP_CLOSE;
			F_RECT:   cmd_d.op = OP_RECT;
			F_CIRCLE: cmd_d.op = OP_ELLIPSE;
			F_RRECT_UNI: begin
				cmd_d.op = (rad_a == '0) ? OP_RECT : OP_RRECT;
			end
			F_RRECT_FOUR: begin
				cmd_d.op = OP_RRECT;
				cmd_d.rb = rad_b;
				cmd_d.rc = rad_c;
				cmd_d.rd = rad_d;
			end
			F_ELLIPSE: begin
				cmd_d.op = OP_ELLIPSE;
				cmd_d.rb = rad_b;
			end
			default: keep_d = 1'b0;
		endcase
	end

	// one register stage ahead of the queue
	assign load     = !valid_s1 || !q_stat.full;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid && keep_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign push     = valid_s1 && !q_stat.full;
	assign push_cmd = cmd_s1;

endmodule

### src/pcs_fifo.sv
module pcs_fifo import pcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	output q_stat_t q_stat,
	input  logic    pop,
	output cmd_t    head
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign q_stat.full  = (cnt_q == (PTR_W+1)'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

### src/pcs_back.sv
module pcs_back import pcs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    head,
	input  logic                    head_valid,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              seg_kind,
	output logic signed [CRD_W-1:0] q0_x,
	output logic signed [CRD_W-1:0] q0_y,
	output logic signed [CRD_W-1:0] q1_x,
	output logic signed [CRD_W-1:0] q1_y,
	output logic signed [CRD_W-1:0] q2_x,
	output logic signed [CRD_W-1:0] q2_y,
	output logic signed [CRD_W-1:0] q3_x,
	output logic signed [CRD_W-1:0] q3_y,
	output logic                    last_seg
);

	localparam logic [31:0] ARC_Q32 = 32'd2370456980;

	typedef enum logic {BS_IDLE, BS_EMIT} bstate_t;
	typedef logic signed [CRD_W-1:0] crd_t;

	function automatic crd_t sadd(input crd_t a, input crd_t b);
		logic [CRD_W:0] s;
		s = {a[CRD_W-1], a} + {b[CRD_W-1], b};
		if (s[CRD_W] != s[CRD_W-1]) begin
			sadd = s[CRD_W] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
		end else begin
			sadd = s[CRD_W-1:0];
		end
	endfunction

	function automatic crd_t ssub(input crd_t a, input crd_t b);
		logic [CRD_W:0] s;
		s = {a[CRD_W-1], a} - {b[CRD_W-1], b};
		if (s[CRD_W] != s[CRD_W-1]) begin
			ssub = s[CRD_W] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
		end else begin
			ssub = s[CRD_W-1:0];
		end
	endfunction

	// radius times the arc constant, rounded half up
	function automatic crd_t magic(input logic [RAD_W-1:0] r);
		logic [63:0] p;
		p = 64'(r) * 64'(ARC_Q32) + 64'h8000_0000;
		magic = p[63:32];
	endfunction

	bstate_t    state_q, state_d;
	logic [2:0] idx_q, last_q;
	op_t        op_q;

	crd_t cur_x_q, cur_y_q, start_x_q, start_y_q, pc_x_q, pc_y_q;
	logic [1:0] prev_kind_q;

	// single segment, prepared on pop
	logic [1:0] sk_q;
	crd_t s1x_q, s1y_q, s2x_q, s2y_q, s3x_q, s3y_q, s0x_q, s0y_q;

	// shape terms, prepared on pop
	crd_t ox_q, oy_q, r_q, b_q;
	crd_t xtl_q, xtr_q, ytr_q, ybr_q, xbr_q, xbl_q, ybl_q, ytl_q;
	crd_t xr_q, xd_q, yr_q, yd_q;
	crd_t ma_q, mb_q, mc_q, md_q;

	// prep values from the queue head
	crd_t px, py, k1x, k1y, k2x, k2y, rfx, rfy, rfqx, rfqy, rfcx, rfcy;
	crd_t ta, tb, tc, td, r_d, b_d, xr_d, yr_d;
	logic [1:0] sk_d;
	crd_t s1x_d, s1y_d, s2x_d, s2y_d, s3x_d, s3y_d;
	crd_t ncx, ncy;
	logic [2:0] last_d;
	logic emits_d;

	always_comb begin
		ta   = crd_t'(head.ra);
		tb   = crd_t'(head.rb);
		tc   = crd_t'(head.rc);
		td   = crd_t'(head.rd);
		px   = head.rel ? sadd(cur_x_q, head.ax) : head.ax;
		py   = head.rel ? sadd(cur_y_q, head.ay) : head.ay;
		k1x  = head.rel ? sadd(cur_x_q, head.bx) : head.bx;
		k1y  = head.rel ? sadd(cur_y_q, head.by) : head.by;
		k2x  = head.rel ? sadd(cur_x_q, head.cx) : head.cx;
		k2y  = head.rel ? sadd(cur_y_q, head.cy) : head.cy;
		rfx  = sadd(cur_x_q, ssub(cur_x_q, pc_x_q));
		rfy  = sadd(cur_y_q, ssub(cur_y_q, pc_y_q));
		rfqx = (prev_kind_q == SEG_QUAD) ? rfx : cur_x_q;
		rfqy = (prev_kind_q == SEG_QUAD) ? rfy : cur_y_q;
		rfcx = (prev_kind_q == SEG_CUBIC) ? rfx : cur_x_q;
		rfcy = (prev_kind_q == SEG_CUBIC) ? rfy : cur_y_q;
		r_d  = sadd(head.ax, head.bx);
		b_d  = sadd(head.ay, head.by);
		xr_d = sadd(head.ax, ta);
		yr_d = sadd(head.ay, tb);

		sk_d    = SEG_LINE;
		s1x_d   = px;
		s1y_d   = py;
		s2x_d   = '0;
		s2y_d   = '0;
		s3x_d   = '0;
		s3y_d   = '0;
		ncx     = px;
		ncy     = py;
		last_d  = 3'd0;
		emits_d = 1'b1;
		case (head.op)
			OP_MOVE: emits_d = 1'b0;
			OP_LINE: ;
			OP_HLINE: begin
				s1y_d = cur_y_q;
				ncy   = cur_y_q;
			end
			OP_VLINE: begin
				s1x_d = cur_x_q;
				ncx   = cur_x_q;
			end
			OP_QUAD: begin
				sk_d  = SEG_QUAD;
				s1x_d = k1x;
				s1y_d = k1y;
				s2x_d = px;
				s2y_d = py;
			end
			OP_SQUAD: begin
				sk_d  = SEG_QUAD;
				s1x_d = rfqx;
				s1y_d = rfqy;
				s2x_d = px;
				s2y_d = py;
			end
			OP_CUBIC: begin
				sk_d  = SEG_CUBIC;
				s1x_d = k1x;
				s1y_d = k1y;
				s2x_d = k2x;
				s2y_d = k2y;
				s3x_d = px;
				s3y_d = py;
			end
			OP_SCUBIC: begin
				sk_d  = SEG_CUBIC;
				s1x_d = rfcx;
				s1y_d = rfcy;
				s2x_d = k2x;
				s2y_d = k2y;
				s3x_d = px;
				s3y_d = py;
			end
			OP_CLOSE: begin
				s1x_d = start_x_q;
				s1y_d = start_y_q;
				ncx   = start_x_q;
				ncy   = start_y_q;
			end
			OP_RECT: begin
				ncx    = head.ax;
				ncy    = head.ay;
				last_d = 3'd3;
			end
			OP_RRECT: begin
				ncx    = sadd(head.ax, ta);
				ncy    = head.ay;
				last_d = 3'd7;
			end
			OP_ELLIPSE: begin
				ncx    = head.ax;
				ncy    = yr_d;
				last_d = 3'd3;
			end
			default: emits_d = 1'b0;
		endcase
	end

	// output slot and sequencing
	logic slot_free, emit;
	assign slot_free = !out_valid || !out_stall;
	assign emit      = (state_q == BS_EMIT) && slot_free;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BS_IDLE: begin
				pop = head_valid;
				if (head_valid && emits_d) begin
					state_d = BS_EMIT;
				end
			end
			BS_EMIT: begin
				if (slot_free && idx_q == last_q) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			idx_q   <= '0;
			last_q  <= '0;
			op_q    <= OP_MOVE;
		end else begin
			state_q <= state_d;
			if (pop) begin
				idx_q  <= '0;
				last_q <= last_d;
				op_q   <= head.op;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// prepared operands
	always_ff @(posedge clk) begin
		if (pop) begin
			sk_q  <= sk_d;
			s0x_q <= cur_x_q;
			s0y_q <= cur_y_q;
			s1x_q <= s1x_d;
			s1y_q <= s1y_d;
			s2x_q <= s2x_d;
			s2y_q <= s2y_d;
			s3x_q <= s3x_d;
			s3y_q <= s3y_d;
			ox_q  <= head.ax;
			oy_q  <= head.ay;
			r_q   <= r_d;
			b_q   <= b_d;
			xtl_q <= sadd(head.ax, ta);
			xtr_q <= ssub(r_d, tb);
			ytr_q <= sadd(head.ay, tb);
			ybr_q <= ssub(b_d, tc);
			xbr_q <= ssub(r_d, tc);
			xbl_q <= sadd(head.ax, td);
			ybl_q <= ssub(b_d, td);
			ytl_q <= sadd(head.ay, ta);
			xr_q  <= xr_d;
			xd_q  <= sadd(head.ax, sadd(ta, ta));
			yr_q  <= yr_d;
			yd_q  <= sadd(head.ay, sadd(tb, tb));
			ma_q  <= magic(head.ra);
			mb_q  <= magic(head.rb);
			mc_q  <= magic(head.rc);
			md_q  <= magic(head.rd);
		end
	end

	// segment selection
	logic [1:0] ek;
	crd_t e0x, e0y, e1x, e1y, e2x, e2y, e3x, e3y;
	crd_t xr_pw, xr_mw, yr_ph, yr_mh;
	crd_t xtr_p, ytr_m, ybr_p, xbr_p, xbl_m, ybl_p, ytl_m, xtl_m;

	always_comb begin
		xr_pw = sadd(xr_q, ma_q);
		xr_mw = ssub(xr_q, ma_q);
		yr_ph = sadd(yr_q, mb_q);
		yr_mh = ssub(yr_q, mb_q);
		xtr_p = sadd(xtr_q, mb_q);
		ytr_m = ssub(ytr_q, mb_q);
		ybr_p = sadd(ybr_q, mc_q);
		xbr_p = sadd(xbr_q, mc_q);
		xbl_m = ssub(xbl_q, md_q);
		ybl_p = sadd(ybl_q, md_q);
		ytl_m = ssub(ytl_q, ma_q);
		xtl_m = ssub(xtl_q, ma_q);

		ek  = sk_q;
		e0x = s0x_q;
		e0y = s0y_q;
		e1x = s1x_q;
		e1y = s1y_q;
		e2x = s2x_q;
		e2y = s2y_q;
		e3x = s3x_q;
		e3y = s3y_q;
		case (op_q)
			OP_RECT: begin
				ek  = SEG_LINE;
				e2x = '0;
				e2y = '0;
				e3x = '0;
				e3y = '0;
				case (idx_q)
					3'd0: begin
						e0x = ox_q; e0y = oy_q; e1x = ox_q; e1y = b_q;
					end
					3'd1: begin
						e0x = ox_q; e0y = b_q; e1x = r_q; e1y = b_q;
					end
					3'd2: begin
						e0x = r_q; e0y = b_q; e1x = r_q; e1y = oy_q;
					end
					default: begin
						e0x = r_q; e0y = oy_q; e1x = ox_q; e1y = oy_q;
					end
				endcase
			end
			OP_ELLIPSE: begin
				ek = SEG_CUBIC;
				case (idx_q)
					3'd0: begin
						e0x = xr_q;  e0y = oy_q;  e1x = xr_pw; e1y = oy_q;
						e2x = xd_q;  e2y = yr_mh; e3x = xd_q;  e3y = yr_q;
					end
					3'd1: begin
						e0x = xd_q;  e0y = yr_q;  e1x = xd_q;  e1y = yr_ph;
						e2x = xr_pw; e2y = yd_q;  e3x = xr_q;  e3y = yd_q;
					end
					3'd2: begin
						e0x = xr_q;  e0y = yd_q;  e1x = xr_mw; e1y = yd_q;
						e2x = ox_q;  e2y = yr_ph; e3x = ox_q;  e3y = yr_q;
					end
					default: begin
						e0x = ox_q;  e0y = yr_q;  e1x = ox_q;  e1y = yr_mh;
						e2x = xr_mw; e2y = oy_q;  e3x = xr_q;  e3y = oy_q;
					end
				endcase
			end
			OP_RRECT: begin
				ek  = idx_q[0] ? SEG_CUBIC : SEG_LINE;
				e2x = '0;
				e2y = '0;
				e3x = '0;
				e3y = '0;
				case (idx_q)
					3'd0: begin
						e0x = xtl_q; e0y = oy_q; e1x = xtr_q; e1y = oy_q;
					end
					3'd1: begin
						e0x = xtr_q; e0y = oy_q;  e1x = xtr_p; e1y = oy_q;
						e2x = r_q;   e2y = ytr_m; e3x = r_q;   e3y = ytr_q;
					end
					3'd2: begin
						e0x = r_q; e0y = ytr_q; e1x = r_q; e1y = ybr_q;
					end
					3'd3: begin
						e0x = r_q;   e0y = ybr_q; e1x = r_q;   e1y = ybr_p;
						e2x = xbr_p; e2y = b_q;   e3x = xbr_q; e3y = b_q;
					end
					3'd4: begin
						e0x = xbr_q; e0y = b_q; e1x = xbl_q; e1y = b_q;
					end
					3'd5: begin
						e0x = xbl_q; e0y = b_q;   e1x = xbl_m; e1y = b_q;
						e2x = ox_q;  e2y = ybl_p; e3x = ox_q;  e3y = ybl_q;
					end
					3'd6: begin
						e0x = ox_q; e0y = ybl_q; e1x = ox_q; e1y = ytl_q;
					end
					default: begin
						e0x = ox_q;  e0y = ytl_q; e1x = ox_q;  e1y = ytl_m;
						e2x = xtl_m; e2y = oy_q;  e3x = xtl_q; e3y = oy_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	// path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			start_x_q   <= '0;
			start_y_q   <= '0;
			pc_x_q      <= '0;
			pc_y_q      <= '0;
			prev_kind_q <= SEG_NONE;
		end else begin
			if (pop) begin
				cur_x_q <= ncx;
				cur_y_q <= ncy;
				if (head.op == OP_MOVE) begin
					start_x_q <= px;
					start_y_q <= py;
				end
			end
			if (emit) begin
				prev_kind_q <= ek;
				if (ek == SEG_QUAD) begin
					pc_x_q <= e1x;
					pc_y_q <= e1y;
				end else if (ek == SEG_CUBIC) begin
					pc_x_q <= e2x;
					pc_y_q <= e2y;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (slot_free) begin
			out_valid <= (state_q == BS_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			seg_kind <= ek;
			q0_x     <= e0x;
			q0_y     <= e0y;
			q1_x     <= e1x;
			q1_y     <= e1y;
			q2_x     <= e2x;
			q2_y     <= e2y;
			q3_x     <= e3x;
			q3_y     <= e3y;
			last_seg <= (idx_q == last_q);
		end
	end

endmodule

### src/path_command_segmenter_top.sv
// channel  | direction | handshake           | payload
// command  | in        | in_valid / in_stall   | func, relative, pa_*, pb_*, pc_*, rad_a..rad_d
// segment  | out       | out_valid / out_stall | seg_kind, q0_*..q3_*, last_seg
//
// a command passes through the front register and the queue, is prepared into
// registers when the back end pops it, then leaves one segment per cycle while
// out_stall is low (one for path commands, four for rects and ellipses, eight for
// rounded rects); a move is only popped and emits no segment. a new command is
// popped only after the last segment of the current one has been emitted.
// reset clears the queue, the sequencer, the current point and subpath start.
// the two-entry queue lets commands land while the segment output is stalled.
module path_command_segmenter_top import pcs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [3:0]              func,
	input  logic                    relative,
	input  logic signed [CRD_W-1:0] pa_x,
	input  logic signed [CRD_W-1:0] pa_y,
	input  logic signed [CRD_W-1:0] pb_x,
	input  logic signed [CRD_W-1:0] pb_y,
	input  logic signed [CRD_W-1:0] pc_x,
	input  logic signed [CRD_W-1:0] pc_y,
	input  logic [RAD_W-1:0]        rad_a,
	input  logic [RAD_W-1:0]        rad_b,
	input  logic [RAD_W-1:0]        rad_c,
	input  logic [RAD_W-1:0]        rad_d,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              seg_kind,
	output logic signed [CRD_W-1:0] q0_x,
	output logic signed [CRD_W-1:0] q0_y,
	output logic signed [CRD_W-1:0] q1_x,
	output logic signed [CRD_W-1:0] q1_y,
	output logic signed [CRD_W-1:0] q2_x,
	output logic signed [CRD_W-1:0] q2_y,
	output logic signed [CRD_W-1:0] q3_x,
	output logic signed [CRD_W-1:0] q3_y,
	output logic                    last_seg
);

	q_stat_t q_stat;
	logic    push, pop;
	cmd_t    push_cmd, head;

	// classify and register commands
	pcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.relative (relative),
		.pa_x     (pa_x),
		.pa_y     (pa_y),
		.pb_x     (pb_x),
		.pb_y     (pb_y),
		.pc_x     (pc_x),
		.pc_y     (pc_y),
		.rad_a    (rad_a),
		.rad_b    (rad_b),
		.rad_c    (rad_c),
		.rad_d    (rad_d),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decoupling queue
	pcs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.q_stat   (q_stat),
		.pop      (pop),
		.head     (head)
	);

	// segment generation and path state
	pcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_stat.empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.seg_kind   (seg_kind),
		.q0_x       (q0_x),
		.q0_y       (q0_y),
		.q1_x       (q1_x),
		.q1_y       (q1_y),
		.q2_x       (q2_x),
		.q2_y       (q2_y),
		.q3_x       (q3_x),
		.q3_y       (q3_y),
		.last_seg   (last_seg)
	);

endmodule
